[sv/assert_macros.svh]
// assertion macros used by the rtl file closest_point_triangle_edges_core
// expects a clock and an active-low reset to be passed in
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CPTE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define CPTE_ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition seen");
`else
`define CPTE_ASSERT(lbl, clk, rst_n, prop)
`define CPTE_ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

[sv/cpte_pkg.sv]
// types and constants of the triangle edge closest point pipeline
// no dependencies
package cpte_pkg;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned DiffW    = 33;
  localparam int unsigned ProdW    = 66;
  localparam int unsigned SumW     = 68;
  localparam int unsigned TW       = 31;
  localparam int unsigned TFrac    = 30;
  localparam int unsigned DotLat   = 4;
  localparam int unsigned PointLat = 4;
  localparam int unsigned LaneLat  = DotLat + TFrac + PointLat;

  localparam logic [TW-1:0] TOne = 31'h4000_0000;

  localparam logic [1:0] EDGE_01 = 2'd0;
  localparam logic [1:0] EDGE_12 = 2'd1;
  localparam logic [1:0] EDGE_20 = 2'd2;

  typedef logic [2:0][CoordW-1:0] point_t;
  typedef logic [2:0][DiffW-1:0]  delta_t;

  typedef struct packed {
    point_t a;
    delta_t d;
    point_t p;
    logic   degen;
  } geom_t;

  typedef struct packed {
    logic [SumW-1:0] r;
    logic [SumW-1:0] len;
    logic [TW-1:0]   t;
    logic            done;
  } quot_t;
endpackage

[sv/closest_point_triangle_edges_core.sv]
// closest point on triangle edges: an input beat passes the edge lanes and then the output register
// throughput one beat per cycle while the output is not stalled; the 30-step divider chain sets the depth
// a stalled output freezes the whole pipeline, nothing is dropped
// rst_ni asynchronously clears all valid bits; data registers are not reset
`include "assert_macros.svh"
module closest_point_triangle_edges_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // v0 x,y,z, v1 x,y,z, v2 x,y,z, query x,y,z, 32 bits each from the lowest bit
  input  logic [383:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // nearest x,y,z (32 each), edge_index (2), distance_squared (64),
  // degenerate_edge (1), zero pad (5)
  output logic [167:0] m_axis_tdata
);
  import cpte_pkg::*;

  logic en;
  logic [LaneLat-1:0] vld_q;
  logic out_vld_q;
  point_t v [3];
  point_t qp;
  point_t pt [3];
  logic [SumW-1:0] lane_dist [3];
  logic [2:0] dg;
  logic [1:0] win;
  logic [SumW-1:0] win_dist;
  point_t win_pt;
  logic [CoordW*3-1:0] pt_q;
  logic [1:0] idx_q;
  logic [63:0] dist_q;
  logic dg_q;
  logic win_ok;
  logic idx_ok;

  assign en = m_axis_tready || !out_vld_q;
  assign s_axis_tready = en;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        v[k][j] = s_axis_tdata[(k*3+j)*CoordW +: CoordW];
      end
      qp[k] = s_axis_tdata[(9+k)*CoordW +: CoordW];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    cpte_lane u_lane (
      .clk_i, .en_i(en), .a_i(v[k]), .b_i(v[(k+1)%3]), .p_i(qp),
      .point_o(pt[k]), .dist_o(lane_dist[k]), .degen_o(dg[k])
    );
  end

  // edge 0 needs strict wins over both, then edge 1 over edge 2
  always_comb begin
    if (lane_dist[0] < lane_dist[1] && lane_dist[0] < lane_dist[2]) begin
      win = EDGE_01;
    end else if (lane_dist[1] < lane_dist[2]) begin
      win = EDGE_12;
    end else begin
      win = EDGE_20;
    end
    case (win)
      EDGE_01: begin win_dist = lane_dist[0]; win_pt = pt[0]; end
      EDGE_12: begin win_dist = lane_dist[1]; win_pt = pt[1]; end
      default: begin win_dist = lane_dist[2]; win_pt = pt[2]; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[LaneLat-2:0], s_axis_tvalid};
      out_vld_q <= vld_q[LaneLat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pt_q   <= {win_pt[2], win_pt[1], win_pt[0]};
      idx_q  <= win;
      dist_q <= (win_dist[SumW-1:64] != '0) ? '1 : win_dist[63:0];
      dg_q   <= |dg;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b0, dg_q, dist_q, idx_q, pt_q};

  assign win_ok = (win_dist <= lane_dist[0]) && (win_dist <= lane_dist[1])
               && (win_dist <= lane_dist[2]);
  assign idx_ok = (idx_q == EDGE_01) || (idx_q == EDGE_12) || (idx_q == EDGE_20);

  `CPTE_ASSERT(a_hold_on_stall, clk_i, rst_ni, (!en |=> $stable(vld_q)))
  `CPTE_ASSERT(a_win_is_min, clk_i, rst_ni, (vld_q[LaneLat-1] |-> win_ok))
  `CPTE_ASSERT_NEVER(a_edge_code, clk_i, rst_ni, (m_axis_tvalid && !idx_ok))
endmodule

[sv/cpte_dot.sv]
// edge vectors, dot products and parameter classification, four stages
// depends on cpte_pkg
module cpte_dot (
  input  logic            clk_i,
  input  logic            en_i,
  input  cpte_pkg::point_t a_i,
  input  cpte_pkg::point_t b_i,
  input  cpte_pkg::point_t p_i,
  output cpte_pkg::geom_t  geom_o,
  output cpte_pkg::quot_t  quot_o
);
  import cpte_pkg::*;

  geom_t g1_q, g2_q, g3_q, g4_q;
  delta_t e1_q;
  logic [2:0][ProdW-1:0] ed_q, dd_q;
  logic [SumW-1:0] dot_q, len_q;
  quot_t q4_q;

  delta_t d_d, e_d;
  logic [2:0][ProdW-1:0] ed_d, dd_d;
  logic [SumW-1:0] dot_d, len_d;
  logic pos, degen, ge;
  quot_t q_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_d[i] = {b_i[i][CoordW-1], b_i[i]} - {a_i[i][CoordW-1], a_i[i]};
      e_d[i] = {p_i[i][CoordW-1], p_i[i]} - {a_i[i][CoordW-1], a_i[i]};
      ed_d[i] = ProdW'($signed(e1_q[i]) * $signed(g1_q.d[i]));
      dd_d[i] = ProdW'($signed(g1_q.d[i]) * $signed(g1_q.d[i]));
    end
    dot_d = {{2{ed_q[0][ProdW-1]}}, ed_q[0]} + {{2{ed_q[1][ProdW-1]}}, ed_q[1]}
          + {{2{ed_q[2][ProdW-1]}}, ed_q[2]};
    len_d = {2'b00, dd_q[0]} + {2'b00, dd_q[1]} + {2'b00, dd_q[2]};
    // classify: t is zero, one, or needs the divider
    pos    = !dot_q[SumW-1] && (dot_q != '0);
    degen  = (len_q == '0);
    ge     = (dot_q >= len_q);
    q_d.r    = dot_q;
    q_d.len  = len_q;
    q_d.done = degen || !pos || ge;
    q_d.t    = (pos && !degen && ge) ? TOne : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g1_q <= '{a: a_i, d: d_d, p: p_i, degen: 1'b0};
      e1_q <= e_d;
      g2_q <= g1_q;
      ed_q <= ed_d;
      dd_q <= dd_d;
      g3_q <= g2_q;
      dot_q <= dot_d;
      len_q <= len_d;
      g4_q <= '{a: g3_q.a, d: g3_q.d, p: g3_q.p, degen: degen};
      q4_q <= q_d;
    end
  end

  assign geom_o = g4_q;
  assign quot_o = q4_q;
endmodule

[sv/cpte_div.sv]
// one restoring division step of the projection parameter
// depends on cpte_pkg
module cpte_div (
  input  logic            clk_i,
  input  logic            en_i,
  input  cpte_pkg::geom_t geom_i,
  input  cpte_pkg::quot_t quot_i,
  output cpte_pkg::geom_t geom_o,
  output cpte_pkg::quot_t quot_o
);
  import cpte_pkg::*;

  geom_t geom_q;
  quot_t quot_q, quot_d;
  logic [SumW-1:0] r2;

  always_comb begin
    quot_d = quot_i;
    r2 = {quot_i.r[SumW-2:0], 1'b0};
    if (!quot_i.done) begin
      if (r2 >= quot_i.len) begin
        quot_d.r = r2 - quot_i.len;
        quot_d.t = {quot_i.t[TW-2:0], 1'b1};
      end else begin
        quot_d.r = r2;
        quot_d.t = {quot_i.t[TW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geom_q <= geom_i;
      quot_q <= quot_d;
    end
  end

  assign geom_o = geom_q;
  assign quot_o = quot_q;
endmodule

[sv/cpte_point.sv]
// edge point from the parameter and its squared distance, four stages
// depends on cpte_pkg
module cpte_point (
  input  logic              clk_i,
  input  logic              en_i,
  input  cpte_pkg::geom_t   geom_i,
  input  cpte_pkg::quot_t   quot_i,
  output cpte_pkg::point_t  point_o,
  output logic [cpte_pkg::SumW-1:0] dist_o,
  output logic              degen_o
);
  import cpte_pkg::*;

  geom_t g1_q;
  logic [2:0][64:0] prod_q, prod_d;
  point_t c2_q, c3_q, c4_q, c_d;
  delta_t diff_q, diff_d;
  logic [2:0][ProdW-1:0] sq_q, sq_d;
  logic [3:1] dg_q;
  logic [SumW-1:0] dist_q, dist_d;
  logic [2:0][64:0] rnd;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_d[i] = 65'($signed(geom_i.d[i]) * $signed({1'b0, quot_i.t}));
      // round half up, then floor shift
      rnd[i] = prod_q[i] + 65'h2000_0000;
      c_d[i] = g1_q.a[i] + rnd[i][61:30];
      diff_d[i] = {g1_q.p[i][CoordW-1], g1_q.p[i]} - {c_d[i][CoordW-1], c_d[i]};
      sq_d[i] = ProdW'($signed(diff_q[i]) * $signed(diff_q[i]));
    end
    dist_d = {2'b00, sq_q[0]} + {2'b00, sq_q[1]} + {2'b00, sq_q[2]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g1_q   <= geom_i;
      prod_q <= prod_d;
      c2_q   <= c_d;
      diff_q <= diff_d;
      dg_q   <= {dg_q[2:1], g1_q.degen};
      c3_q   <= c2_q;
      sq_q   <= sq_d;
      c4_q   <= c3_q;
      dist_q <= dist_d;
    end
  end

  assign point_o = c4_q;
  assign dist_o  = dist_q;
  assign degen_o = dg_q[3];
endmodule

[sv/cpte_lane.sv]
// one edge: dot products, divider chain and edge point
// depends on cpte_pkg, cpte_dot, cpte_div, cpte_point
module cpte_lane (
  input  logic              clk_i,
  input  logic              en_i,
  input  cpte_pkg::point_t  a_i,
  input  cpte_pkg::point_t  b_i,
  input  cpte_pkg::point_t  p_i,
  output cpte_pkg::point_t  point_o,
  output logic [cpte_pkg::SumW-1:0] dist_o,
  output logic              degen_o
);
  import cpte_pkg::*;

  geom_t g [TFrac+1];
  quot_t q [TFrac+1];

  cpte_dot u_dot (
    .clk_i, .en_i, .a_i, .b_i, .p_i, .geom_o(g[0]), .quot_o(q[0])
  );

  for (genvar s = 0; s < TFrac; s++) begin : g_div
    cpte_div u_div (
      .clk_i, .en_i, .geom_i(g[s]), .quot_i(q[s]), .geom_o(g[s+1]), .quot_o(q[s+1])
    );
  end

  cpte_point u_point (
    .clk_i, .en_i, .geom_i(g[TFrac]), .quot_i(q[TFrac]), .point_o, .dist_o, .degen_o
  );
endmodule
